>>> src/rmtf_pkg.sv
// Package for the range mapper with threshold flags: widths, reset values,
// register indexes, FSM encoding and the structs shared between the modules.
// No dependencies.
`default_nettype none

package rmtf_pkg;

  // fixed-point format and field widths
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int DIFF_W     = DATA_W + 1;            // x - in_min, spans
  localparam int MAG_W      = DATA_W;                // magnitude of a DIFF_W value
  localparam int NUM_W      = MAG_W + FRAC_BITS;     // scaled dividend magnitude
  localparam int DIV_STEPS  = NUM_W;                 // one quotient bit per cycle
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int F_W        = NUM_W + 1;             // signed normalized value
  localparam int G_MAG_W    = F_W;                   // magnitude of 1 - f or f
  localparam int MUL_CHUNK  = 17;
  localparam int MUL_STEPS  = (G_MAG_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MUL_IDX_W  = $clog2(MUL_STEPS);
  localparam int G_PAD_W    = MUL_STEPS * MUL_CHUNK;
  localparam int PROD_W     = MAG_W + G_PAD_W;
  localparam int SCL_W      = PROD_W - FRAC_BITS;
  localparam int M_W        = DATA_W + 3;            // limited product magnitude
  localparam int P_W        = M_W + 1;               // signed product
  localparam int Y_W        = P_W + 1;               // out_min + product

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2 * DATA_W;
  localparam int MODE_W     = 4;
  localparam int OUT_TDATA_W = 48;                   // 41 payload bits, byte padded

  localparam logic signed [DATA_W-1:0] ONE_FX   = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [F_W-1:0]    ONE_F    = F_W'(1) << FRAC_BITS;
  localparam logic [SCL_W-1:0]         M_LIMIT  = SCL_W'(1) << (DATA_W + 1);
  localparam logic [M_W-1:0]           M_SAT    = M_W'(1) << (DATA_W + 2);
  localparam logic [MODE_W-1:0]        MODE_RST = MODE_W'(1);

  // mode bits
  localparam int MODE_ACTIVE   = 0;
  localparam int MODE_CLIP_LO  = 1;
  localparam int MODE_CLIP_HI  = 2;
  localparam int MODE_INVERSE  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_THR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd6;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_min;
    logic signed [DATA_W-1:0] in_max;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] in_dn;
    logic signed [DATA_W-1:0] in_up;
    logic signed [DATA_W-1:0] out_dn;
    logic signed [DATA_W-1:0] out_up;
    logic [MODE_W-1:0]        mode;
  } rmtf_cfg_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PREP   = 9'b000000010,
    ST_DLOAD  = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_FSEL   = 9'b000010000,
    ST_GSEL   = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_SCALE  = 9'b010000000,
    ST_RESULT = 9'b100000000
  } rmtf_state_t;

  typedef struct packed {
    logic                 load;
    logic                 prep;
    logic                 dload;
    logic                 div_step;
    logic                 fsel;
    logic                 gsel;
    logic                 mul_step;
    logic [MUL_IDX_W-1:0] mul_idx;
    logic                 scale;
    logic                 result;
  } rmtf_cmd_t;

  typedef struct packed {
    logic active;
    logic empty;
    logic out_free;
  } rmtf_stat_t;

endpackage

`default_nettype wire

>>> src/rmtf_ctrl.sv
// Sequencer for the range mapper: one-hot FSM plus divide and multiply
// step counters. Depends on rmtf_pkg.
`default_nettype none

module rmtf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire rmtf_pkg::rmtf_stat_t stat,
  output rmtf_pkg::rmtf_cmd_t       cmd
);

  rmtf_pkg::rmtf_state_t state_r, state_nxt;
  logic [rmtf_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [rmtf_pkg::MUL_IDX_W-1:0] mul_cnt_r, mul_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    mul_cnt_nxt = mul_cnt_r;
    cmd         = '0;
    cmd.mul_idx = mul_cnt_r;
    in_tready   = 1'b0;
    case (state_r)
      rmtf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // beats taken while inactive are dropped
          if (stat.active) state_nxt = rmtf_pkg::ST_PREP;
        end
      end
      rmtf_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = rmtf_pkg::ST_DLOAD;
      end
      rmtf_pkg::ST_DLOAD: begin
        cmd.dload   = 1'b1;
        div_cnt_nxt = rmtf_pkg::DIV_CNT_W'(rmtf_pkg::DIV_STEPS - 1);
        state_nxt   = stat.empty ? rmtf_pkg::ST_FSEL : rmtf_pkg::ST_DIV;
      end
      rmtf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) state_nxt = rmtf_pkg::ST_FSEL;
        else div_cnt_nxt = div_cnt_r - rmtf_pkg::DIV_CNT_W'(1);
      end
      rmtf_pkg::ST_FSEL: begin
        cmd.fsel  = 1'b1;
        state_nxt = rmtf_pkg::ST_GSEL;
      end
      rmtf_pkg::ST_GSEL: begin
        cmd.gsel    = 1'b1;
        mul_cnt_nxt = '0;
        state_nxt   = rmtf_pkg::ST_MUL;
      end
      rmtf_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (mul_cnt_r == rmtf_pkg::MUL_IDX_W'(rmtf_pkg::MUL_STEPS - 1)) begin
          state_nxt = rmtf_pkg::ST_SCALE;
        end else begin
          mul_cnt_nxt = mul_cnt_r + rmtf_pkg::MUL_IDX_W'(1);
        end
      end
      rmtf_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = rmtf_pkg::ST_RESULT;
      end
      rmtf_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = rmtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rmtf_pkg::ST_IDLE;
      div_cnt_r <= '0;
      mul_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      mul_cnt_r <= mul_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/rmtf_dpath.sv
// Datapath of the range mapper: clip, restoring divider, chunked multiplier,
// saturation, threshold flags and the output register. Depends on rmtf_pkg.
`default_nettype none

module rmtf_dpath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire rmtf_pkg::rmtf_cfg_t                   cfg,
  input  wire rmtf_pkg::rmtf_cmd_t                   cmd,
  output rmtf_pkg::rmtf_stat_t                       stat,
  input  wire logic [rmtf_pkg::DATA_W-1:0]           sample,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [rmtf_pkg::OUT_TDATA_W-1:0]           out_tdata
);

  localparam int DW = rmtf_pkg::DATA_W;
  localparam int XW = rmtf_pkg::DIFF_W;
  localparam int MW = rmtf_pkg::MAG_W;
  localparam int NW = rmtf_pkg::NUM_W;
  localparam int FW = rmtf_pkg::F_W;
  localparam int GW = rmtf_pkg::G_MAG_W;
  localparam int CW = rmtf_pkg::MUL_CHUNK;
  localparam int PW = rmtf_pkg::PROD_W;
  localparam int YW = rmtf_pkg::Y_W;
  localparam int FB = rmtf_pkg::FRAC_BITS;

  // registers
  logic signed [DW-1:0]          sample_r;
  logic signed [XW-1:0]          d_r, span_r, c_r;
  logic                          empty_r, ib_r, ia_r;
  logic [MW-1:0]                 rem_r, dvs_r, c_mag_r;
  logic [NW-1:0]                 quo_r;
  logic                          q_neg_r, p_neg_r;
  logic signed [FW-1:0]          f_r;
  logic [rmtf_pkg::G_PAD_W-1:0]  g_pad_r;
  logic [PW-1:0]                 acc_r;
  logic signed [rmtf_pkg::P_W-1:0] p_r;
  logic                          out_valid_r;
  logic [rmtf_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                          prev_ib_r, prev_ia_r, prev_ob_r, prev_oa_r;

  // clip, differences and input flags
  logic signed [DW-1:0] x_lo, x_cl;
  logic signed [XW-1:0] d_c, span_c, c_c;
  logic                 ib_c, ia_c;

  always_comb begin
    x_lo   = (cfg.mode[rmtf_pkg::MODE_CLIP_LO] && (sample_r < cfg.in_min)) ?
             cfg.in_min : sample_r;
    x_cl   = (cfg.mode[rmtf_pkg::MODE_CLIP_HI] && (x_lo > cfg.in_max)) ? cfg.in_max : x_lo;
    d_c    = {x_cl[DW-1], x_cl} - {cfg.in_min[DW-1], cfg.in_min};
    span_c = {cfg.in_max[DW-1], cfg.in_max} - {cfg.in_min[DW-1], cfg.in_min};
    c_c    = {cfg.out_max[DW-1], cfg.out_max} - {cfg.out_min[DW-1], cfg.out_min};
    ib_c   = sample_r <= cfg.in_dn;
    ia_c   = sample_r >= cfg.in_up;
  end

  // divider operands
  logic [XW-1:0] d_neg, span_neg;
  logic [MW-1:0] d_mag, span_mag;
  always_comb begin
    d_neg    = -d_r;
    span_neg = -span_r;
    d_mag    = d_r[XW-1] ? d_neg[MW-1:0] : d_r[MW-1:0];
    span_mag = span_r[XW-1] ? span_neg[MW-1:0] : span_r[MW-1:0];
  end

  // one restoring step
  logic [MW:0] trial, trial_sub;
  logic        q_bit;
  always_comb begin
    trial     = {rem_r, quo_r[NW-1]};
    trial_sub = trial - {1'b0, dvs_r};
    q_bit     = trial >= {1'b0, dvs_r};
  end

  // quotient sign / empty range select
  logic [FW-1:0] q_ext, q_neg_v;
  logic signed [FW-1:0] f_c;
  always_comb begin
    q_ext   = {1'b0, quo_r};
    q_neg_v = -q_ext;
    if (empty_r) f_c = {{(FW - XW){d_r[XW-1]}}, d_r};
    else         f_c = q_neg_r ? q_neg_v : q_ext;
  end

  // inverse and magnitudes for the multiplier
  logic signed [FW:0] fe, one_e, one_m_f, f_m_one, f_negv;
  logic               g_neg;
  logic [FW:0]        g_mag_w;
  logic [XW-1:0]      c_negv;
  always_comb begin
    fe      = {f_r[FW-1], f_r};
    one_e   = {1'b0, rmtf_pkg::ONE_F};
    one_m_f = one_e - fe;
    f_m_one = fe - one_e;
    f_negv  = -fe;
    if (cfg.mode[rmtf_pkg::MODE_INVERSE]) begin
      g_neg   = f_r > rmtf_pkg::ONE_F;
      g_mag_w = g_neg ? f_m_one : one_m_f;
    end else begin
      g_neg   = f_r[FW-1];
      g_mag_w = g_neg ? f_negv : fe;
    end
    c_negv = -c_r;
  end

  // partial product for the current chunk
  logic [CW-1:0]    chunk;
  logic [MW+CW-1:0] pp;
  logic [PW-1:0]    acc_add;
  always_comb begin
    chunk   = g_pad_r[cmd.mul_idx * CW +: CW];
    pp      = (MW+CW)'(c_mag_r) * (MW+CW)'(chunk);
    acc_add = acc_r + (PW'(pp) << (cmd.mul_idx * CW));
  end

  // drop fraction bits, limit and sign
  logic [rmtf_pkg::SCL_W-1:0] scaled;
  logic [rmtf_pkg::M_W-1:0]   m_c;
  logic [rmtf_pkg::P_W-1:0]   m_ext, m_negv;
  always_comb begin
    scaled = acc_r[PW-1:FB];
    m_c    = (scaled > rmtf_pkg::M_LIMIT) ? rmtf_pkg::M_SAT : scaled[rmtf_pkg::M_W-1:0];
    m_ext  = {1'b0, m_c};
    m_negv = -m_ext;
  end

  // offset, saturate, output flags
  logic signed [YW-1:0] y_c;
  logic                 sat_c, ob_c, oa_c;
  logic signed [DW-1:0] mapped_c;
  always_comb begin
    y_c   = {{(YW - DW){cfg.out_min[DW-1]}}, cfg.out_min} + {p_r[rmtf_pkg::P_W-1], p_r};
    // fits 32 bits when all bits from the sign of a 32-bit value upward agree
    sat_c = !((&y_c[YW-1:DW-1]) || !(|y_c[YW-1:DW-1]));
    if (sat_c) mapped_c = y_c[YW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else       mapped_c = y_c[DW-1:0];
    ob_c = mapped_c <= cfg.out_dn;
    oa_c = mapped_c >= cfg.out_up;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= sample;
    if (cmd.prep) begin
      d_r     <= d_c;
      span_r  <= span_c;
      c_r     <= c_c;
      empty_r <= cfg.in_min == cfg.in_max;
      ib_r    <= ib_c;
      ia_r    <= ia_c;
    end
    if (cmd.dload) begin
      rem_r   <= '0;
      quo_r   <= {d_mag, {FB{1'b0}}};
      dvs_r   <= span_mag;
      q_neg_r <= d_r[XW-1] ^ span_r[XW-1];
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? trial_sub[MW-1:0] : trial[MW-1:0];
      quo_r <= {quo_r[NW-2:0], q_bit};
    end
    if (cmd.fsel) f_r <= f_c;
    if (cmd.gsel) begin
      g_pad_r <= {{(rmtf_pkg::G_PAD_W - GW){1'b0}}, g_mag_w[GW-1:0]};
      c_mag_r <= c_r[XW-1] ? c_negv[MW-1:0] : c_r[MW-1:0];
      p_neg_r <= c_r[XW-1] ^ g_neg;
      acc_r   <= '0;
    end
    if (cmd.mul_step) acc_r <= acc_add;
    if (cmd.scale) p_r <= p_neg_r ? m_negv : m_ext;
    if (cmd.result) begin
      out_data_r <= {{(rmtf_pkg::OUT_TDATA_W - DW - 10){1'b0}},
                     oa_c ^ prev_oa_r, ob_c ^ prev_ob_r, ia_r ^ prev_ia_r, ib_r ^ prev_ib_r,
                     oa_c, ob_c, ia_r, ib_r, sat_c, mapped_c};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_ib_r   <= 1'b0;
      prev_ia_r   <= 1'b0;
      prev_ob_r   <= 1'b0;
      prev_oa_r   <= 1'b0;
    end else begin
      if (cmd.result) begin
        out_valid_r <= 1'b1;
        prev_ib_r   <= ib_r;
        prev_ia_r   <= ia_r;
        prev_ob_r   <= ob_c;
        prev_oa_r   <= oa_c;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.active   = cfg.mode[rmtf_pkg::MODE_ACTIVE];
  assign stat.empty    = empty_r;
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

`default_nettype wire

>>> src/range_mapper_with_threshold_flags.sv
// Top level of the range mapper with threshold flags: configuration
// registers and the controller/datapath pair. Depends on rmtf_pkg,
// rmtf_ctrl and rmtf_dpath.
//
// Maps each signed Q16.16 sample onto the output range: optional clip to the
// input range, normalize by (x - in_min)/(in_max - in_min) (x - in_min when
// the range is empty), scale onto out_min..out_max, optional inverse, 32-bit
// saturation, and four level flags with change bits. One item is worked at a
// time: the accepted input beat passes the bit-serial restoring divider and
// the 32x17 chunked multiplier on its way to the result; with an empty input
// range the divider is skipped. A new beat is taken in the cycle after the
// result is registered, even while that result waits on out_tready. While
// mode bit 0 is clear, input beats are taken and dropped. Configuration is
// always ready and must only be written while the block is idle; unknown
// indexes are ignored.
`default_nettype none

module range_mapper_with_threshold_flags (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // sample[31:0]
  input  wire logic [rmtf_pkg::DATA_W-1:0]          in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // mapped[31:0], saturated[32], in_below[33], in_above[34], out_below[35],
  // out_above[36], in_below_changed[37], in_above_changed[38],
  // out_below_changed[39], out_above_changed[40], zero padding [47:41]
  output logic [rmtf_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rmtf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rmtf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DW = rmtf_pkg::DATA_W;

  rmtf_pkg::rmtf_cfg_t  cfg_r;
  rmtf_pkg::rmtf_cmd_t  cmd;
  rmtf_pkg::rmtf_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_min  <= '0;
      cfg_r.in_max  <= rmtf_pkg::ONE_FX;
      cfg_r.out_min <= '0;
      cfg_r.out_max <= rmtf_pkg::ONE_FX;
      cfg_r.in_dn   <= '0;
      cfg_r.in_up   <= rmtf_pkg::ONE_FX;
      cfg_r.out_dn  <= '0;
      cfg_r.out_up  <= rmtf_pkg::ONE_FX;
      cfg_r.mode    <= rmtf_pkg::MODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rmtf_pkg::REG_IN_MIN:  cfg_r.in_min  <= cfg_data[DW-1:0];
        rmtf_pkg::REG_IN_MAX:  cfg_r.in_max  <= cfg_data[DW-1:0];
        rmtf_pkg::REG_OUT_MIN: cfg_r.out_min <= cfg_data[DW-1:0];
        rmtf_pkg::REG_OUT_MAX: cfg_r.out_max <= cfg_data[DW-1:0];
        rmtf_pkg::REG_IN_THR: begin
          cfg_r.in_dn <= cfg_data[DW-1:0];
          cfg_r.in_up <= cfg_data[2*DW-1:DW];
        end
        rmtf_pkg::REG_OUT_THR: begin
          cfg_r.out_dn <= cfg_data[DW-1:0];
          cfg_r.out_up <= cfg_data[2*DW-1:DW];
        end
        rmtf_pkg::REG_MODE: cfg_r.mode <= cfg_data[rmtf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  rmtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmtf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .stat       (stat),
    .sample     (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
